/* design/bat_pkg.sv */
// Shared types and constants for the buddy allocator tree.
// Holds request codes, result status codes, the result record and the size rounding helper.
// No dependencies.
`default_nettype none

package bat_pkg;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_NOTHING = 2'd2
    } stat_t;

    typedef struct packed {
        logic [7:0] grant_offset;
        stat_t      status;
    } res_t;

    // Log2 of the request size rounded up to a power of two; sizes 0 and 1 both give 0.
    function automatic logic [3:0] size_log(input logic [8:0] size);
        logic [3:0] lg;
        lg = '0;
        for (int i = 0; i < 9; i++) begin
            if (size > 9'(1 << i)) begin
                lg = 4'(i + 1);
            end
        end
        return lg;
    endfunction

endpackage

`default_nettype wire

/* design/bat_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module bat_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 511
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/bat_ctrl.sv */
// Tree walker of the buddy allocator: clearing pass, descent, upward search and merge climb.
// Drives the node memory through one read and one write port. Depends on bat_pkg.
`default_nettype none

module bat_ctrl #(
    parameter int TOTAL_UNITS = 256
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_req_type,
    input  wire logic [8:0]                     s_req_size,
    input  wire logic [7:0]                     s_req_offset,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output bat_pkg::res_t                       res,
    output logic                                mem_we,
    output logic [$clog2(TOTAL_UNITS):0]        mem_waddr,
    output logic [$clog2(TOTAL_UNITS):0]        mem_wdata,
    output logic                                mem_re,
    output logic [$clog2(TOTAL_UNITS):0]        mem_raddr,
    input  wire logic [$clog2(TOTAL_UNITS):0]   mem_rdata
);

    import bat_pkg::*;

    localparam int LVL   = $clog2(TOTAL_UNITS);
    localparam int VW    = LVL + 1;
    localparam int HW    = LVL + 1;
    localparam int NODES = 2 * TOTAL_UNITS - 1;
    localparam int CW    = (VW > 10) ? VW : 10;
    localparam int OW    = (LVL > 8) ? LVL : 8;
    localparam int LW    = $clog2(LVL + 1);

    typedef enum logic [7:0] {
        S_INIT = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_ROOT = 8'b0000_0100,
        S_DOWN = 8'b0000_1000,
        S_SRCH = 8'b0001_0000,
        S_MARK = 8'b0010_0000,
        S_UP   = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [HW-1:0]   h_reg, h_next;
    logic [VW-1:0]   span_reg, span_next;
    logic [VW-1:0]   val_reg, val_next;
    logic [OW-1:0]   off_reg, off_next;
    logic [LW-1:0]   rem_reg, rem_next;
    logic [CW-1:0]   want_reg, want_next;
    logic            alloc_reg, alloc_next;
    res_t            res_reg, res_next;

    logic [HW-1:0]   h_inc;
    logic [HW-1:0]   left_child;
    logic [HW-1:0]   child;
    logic            take_left;
    logic [HW-1:0]   parent;
    logic [VW:0]     pair_sum;
    logic [VW:0]     pair_full;
    logic [VW-1:0]   merged;
    logic [3:0]      req_log;

    assign h_inc      = h_reg + HW'(1);
    assign left_child = {h_reg[HW-2:0], 1'b0};
    assign take_left  = CW'(mem_rdata) >= want_reg;
    assign child      = take_left ? left_child : (left_child | HW'(1));
    assign parent     = h_reg >> 1;
    assign req_log    = size_log(s_req_size);

    // Two buddies that are both whole merge back into their parent's full span.
    assign pair_sum  = {1'b0, val_reg} + {1'b0, mem_rdata};
    assign pair_full = {span_reg, 1'b0};
    always_comb begin
        if (pair_sum == pair_full) begin
            merged = pair_full[VW-1:0];
        end else if (val_reg > mem_rdata) begin
            merged = val_reg;
        end else begin
            merged = mem_rdata;
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb begin
        state_next = state_reg;
        h_next     = h_reg;
        span_next  = span_reg;
        val_next   = val_reg;
        off_next   = off_reg;
        rem_next   = rem_reg;
        want_next  = want_reg;
        alloc_next = alloc_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        case (state_reg)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = h_reg - HW'(1);
                mem_wdata = span_reg;
                h_next    = h_inc;
                // Each new level of the tree starts at a power-of-two node number.
                if ((h_inc & h_reg) == '0) begin
                    span_next = span_reg >> 1;
                end
                if (h_reg == HW'(NODES)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    alloc_next = (s_req_type == REQ_ALLOC);
                    if (s_req_type == REQ_ALLOC) begin
                        want_next  = CW'(1) << req_log;
                        rem_next   = LW'(LVL) - LW'(req_log);
                        span_next  = VW'(TOTAL_UNITS);
                        off_next   = '0;
                        mem_re     = 1'b1;
                        mem_raddr  = '0;
                        state_next = S_ROOT;
                    end else if (32'(s_req_offset) >= 32'(TOTAL_UNITS)) begin
                        res_next   = '{grant_offset: 8'd0, status: ST_NOTHING};
                        state_next = S_DONE;
                    end else begin
                        h_next     = HW'(s_req_offset) + HW'(TOTAL_UNITS);
                        span_next  = VW'(1);
                        mem_re     = 1'b1;
                        mem_raddr  = HW'(s_req_offset) + HW'(TOTAL_UNITS - 1);
                        state_next = S_SRCH;
                    end
                end
            end
            S_ROOT: begin
                if (CW'(mem_rdata) < want_reg) begin
                    res_next   = '{grant_offset: 8'd0, status: ST_NOSPACE};
                    state_next = S_DONE;
                end else begin
                    h_next   = HW'(1);
                    val_next = '0;
                    if (rem_reg == '0) begin
                        state_next = S_MARK;
                    end else begin
                        mem_re     = 1'b1;
                        mem_raddr  = HW'(1);
                        state_next = S_DOWN;
                    end
                end
            end
            S_DOWN: begin
                // The read data is the left child of h_reg.
                span_next = span_reg >> 1;
                if (!take_left) begin
                    off_next = off_reg + OW'(span_reg >> 1);
                end
                h_next   = child;
                rem_next = rem_reg - LW'(1);
                if (rem_reg == LW'(1)) begin
                    state_next = S_MARK;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = {child[HW-2:0], 1'b0} - HW'(1);
                end
            end
            S_SRCH: begin
                // The read data is the node at h_reg; the parent is read as the walk climbs to it.
                if (mem_rdata == '0) begin
                    val_next   = span_reg;
                    state_next = S_MARK;
                end else if (h_reg == HW'(1)) begin
                    res_next   = '{grant_offset: 8'd0, status: ST_NOTHING};
                    state_next = S_DONE;
                end else begin
                    h_next    = parent;
                    span_next = span_reg << 1;
                    mem_re    = 1'b1;
                    mem_raddr = parent - HW'(1);
                end
            end
            S_MARK: begin
                mem_we    = 1'b1;
                mem_waddr = h_reg - HW'(1);
                mem_wdata = val_reg;
                if (h_reg == HW'(1)) begin
                    res_next.grant_offset = alloc_reg ? off_reg[7:0] : 8'd0;
                    res_next.status       = ST_OK;
                    state_next            = S_DONE;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = (h_reg ^ HW'(1)) - HW'(1);
                    state_next = S_UP;
                end
            end
            S_UP: begin
                // The read data is the buddy of h_reg; the parent takes the merged value.
                mem_we    = 1'b1;
                mem_waddr = parent - HW'(1);
                mem_wdata = merged;
                val_next  = merged;
                span_next = span_reg << 1;
                h_next    = parent;
                if (parent == HW'(1)) begin
                    res_next.grant_offset = alloc_reg ? off_reg[7:0] : 8'd0;
                    res_next.status       = ST_OK;
                    state_next            = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = (parent ^ HW'(1)) - HW'(1);
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            h_reg     <= HW'(1);
            span_reg  <= VW'(TOTAL_UNITS);
        end else begin
            state_reg <= state_next;
            h_reg     <= h_next;
            span_reg  <= span_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg   <= val_next;
        off_reg   <= off_next;
        rem_reg   <= rem_next;
        want_reg  <= want_next;
        alloc_reg <= alloc_next;
        res_reg   <= res_next;
    end

endmodule

`default_nettype wire

/* design/buddy_allocator_tree.sv */
// Buddy allocator over TOTAL_UNITS units kept as a binary tree of largest-free-block values.
// Requests are handled one item at a time, since each tree level costs one access of the
// single-read-port node memory going down and going up. After reset a clearing pass writes
// all 2*TOTAL_UNITS-1 nodes, during which s_ready stays low. Depends on bat_pkg, bat_ram
// and bat_ctrl.
`default_nettype none

module buddy_allocator_tree #(
    parameter int TOTAL_UNITS = 256
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_req_type,
    input  wire logic [8:0] s_req_size,
    input  wire logic [7:0] s_req_offset,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_grant_offset,
    output logic [1:0]      m_status
);

    import bat_pkg::*;

    localparam int NW = $clog2(TOTAL_UNITS) + 1;

    logic          res_valid;
    logic          res_ready;
    res_t          res;
    logic          mem_we;
    logic [NW-1:0] mem_waddr;
    logic [NW-1:0] mem_wdata;
    logic          mem_re;
    logic [NW-1:0] mem_raddr;
    logic [NW-1:0] mem_rdata;

    logic          m_valid_reg;
    logic [7:0]    m_grant_offset_reg;
    logic [1:0]    m_status_reg;

    bat_ctrl #(
        .TOTAL_UNITS(TOTAL_UNITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_req_size  (s_req_size),
        .s_req_offset(s_req_offset),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    bat_ram #(
        .WIDTH(NW),
        .DEPTH(2 * TOTAL_UNITS - 1)
    ) u_node_ram (
        .clk  (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // The output register frees the walker as soon as the previous result has been taken.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_grant_offset_reg <= res.grant_offset;
            m_status_reg       <= res.status;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_grant_offset = m_grant_offset_reg;
    assign m_status       = m_status_reg;

    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted again right after a transfer");

    a_no_same_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we && mem_re |-> mem_waddr != mem_raddr)
        else $error("node memory read and written at the same entry");

    a_grant_only_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_grant_offset == 8'd0)
        else $error("nonzero offset on a failed request");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_ready |=> m_valid)
        else $error("result not presented after the walker finished");

endmodule

`default_nettype wire

/* sim/tb_buddy_allocator_tree.sv */
`timescale 1ns / 1ps
// Self-checking testbench for buddy_allocator_tree: a directed table, then random allocate/free
// traffic, checked against a tree predictor kept inside the bench. Depends on bat_pkg and the RTL.
module tb_buddy_allocator_tree;
    import bat_pkg::*;

    localparam int UNITS        = 256;
    localparam int NODES        = 2 * UNITS - 1;
    localparam int RANDOM_ITEMS = 1450;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic       kind;
        logic [8:0] size;
        logic [7:0] offset;
    } req_s;

    typedef struct {
        logic       kind;
        logic [8:0] size;
        logic [7:0] offset;
        bit         typed;
        logic [7:0] t_off;
        stat_t      t_stat;
    } row_s;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_req_type = REQ_ALLOC;
    logic [8:0] s_req_size = '0;
    logic [7:0] s_req_offset = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_grant_offset;
    logic [1:0] m_status;

    // Largest free block below each node, as the block should hold it.
    logic [8:0] free_span [NODES];
    res_t       pending_results [$];
    int         live_base [$];
    int         live_len [$];
    row_s       directed [25];

    int tx_idle_pct = 37;
    int rx_idle_pct = 82;
    int errors = 0;
    int cycle_count = 0;
    int n_granted = 0, n_refused = 0, n_released = 0, n_empty_free = 0;

    buddy_allocator_tree #(.TOTAL_UNITS(UNITS)) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req_type(s_req_type),
        .s_req_size(s_req_size),
        .s_req_offset(s_req_offset),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_grant_offset(m_grant_offset),
        .m_status(m_status)
    );

    always #5 aclk = ~aclk;

    function automatic int pow2_ceil(input logic [8:0] size);
        int p;
        p = 1;
        while (p < int'(size)) p = p << 1;
        return p;
    endfunction

    function automatic void tree_reset();
        int span;
        span = 2 * UNITS;
        for (int n = 0; n < NODES; n++) begin
            if (((n + 1) & n) == 0) span = span >> 1;
            free_span[n] = 9'(span);
        end
    endfunction

    function automatic res_t grant_block(input logic [8:0] size);
        res_t r;
        int   want;
        int   node;
        int   span;
        int   a;
        int   b;
        want = pow2_ceil(size);
        r.grant_offset = '0;
        r.status = ST_NOSPACE;
        if (int'(free_span[0]) < want) return r;
        node = 0;
        // Walk down, taking the left child whenever it can hold the block.
        for (span = UNITS; span > want && span > 1; span = span >> 1) begin
            node = (int'(free_span[2 * node + 1]) >= want) ? 2 * node + 1 : 2 * node + 2;
        end
        free_span[node] = '0;
        r.grant_offset = 8'((node + 1) * span - UNITS);
        r.status = ST_OK;
        while (node != 0) begin
            node = (node + 1) / 2 - 1;
            a = free_span[2 * node + 1];
            b = free_span[2 * node + 2];
            free_span[node] = 9'(a > b ? a : b);
        end
        return r;
    endfunction

    function automatic res_t release_block(input logic [7:0] offset);
        res_t r;
        int   node;
        int   span;
        int   a;
        int   b;
        r.grant_offset = '0;
        r.status = ST_NOTHING;
        node = int'(offset) + UNITS - 1;
        span = 1;
        // Climb to the first used node; an offset inside a block frees the whole block.
        while (free_span[node] != 0) begin
            if (node == 0) return r;
            span = span << 1;
            node = (node + 1) / 2 - 1;
        end
        free_span[node] = 9'(span);
        while (node != 0) begin
            node = (node + 1) / 2 - 1;
            span = span << 1;
            a = free_span[2 * node + 1];
            b = free_span[2 * node + 2];
            // Two fully free buddies merge into one block of the parent's size.
            free_span[node] = (a + b == span) ? 9'(span) : 9'(a > b ? a : b);
        end
        r.status = ST_OK;
        return r;
    endfunction

    task automatic issue(input req_s r, input bit typed, input res_t typed_res);
        res_t res;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= r.kind;
        s_req_size   <= r.size;
        s_req_offset <= r.offset;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (r.kind == REQ_ALLOC) begin
            res = grant_block(r.size);
            if (res.status == ST_OK) begin
                n_granted++;
                live_base.push_back(int'(res.grant_offset));
                live_len.push_back(pow2_ceil(r.size));
            end else begin
                n_refused++;
            end
        end else begin
            res = release_block(r.offset);
            if (res.status == ST_OK) n_released++;
            else n_empty_free++;
        end
        pending_results.push_back(typed ? typed_res : res);
    endtask

    always @(posedge aclk) begin
        res_t want_res;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with none pending: offset %0d stat %0d",
                             $time, m_grant_offset, m_status);
                    errors++;
                end else begin
                    want_res = pending_results.pop_front();
                    if (m_grant_offset !== want_res.grant_offset) begin
                        $display("%0t: grant_offset expected %0d, got %0d",
                                 $time, want_res.grant_offset, m_grant_offset);
                        errors++;
                    end
                    if (m_status !== want_res.status) begin
                        $display("%0t: stat expected %0d, got %0d",
                                 $time, want_res.status, m_status);
                        errors++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results pending",
                     cycle_count, pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        req_s r;
        int   roll;
        int   pick;
        int   idx;
        int   alloc_pct;

        tree_reset();
        // Rows with a typed result are obvious from the tree shape alone.
        directed = '{
            '{REQ_ALLOC, 9'd256, 8'h00, 1'b1, 8'd0, ST_OK},
            '{REQ_ALLOC, 9'd1,   8'hFF, 1'b1, 8'd0, ST_NOSPACE},
            '{REQ_FREE,  9'd0,   8'd0,  1'b1, 8'd0, ST_OK},
            '{REQ_FREE,  9'h1FF, 8'd0,  1'b1, 8'd0, ST_NOTHING},
            '{REQ_ALLOC, 9'd257, 8'h55, 1'b1, 8'd0, ST_NOSPACE},
            '{REQ_ALLOC, 9'd511, 8'hAA, 1'b1, 8'd0, ST_NOSPACE},
            '{REQ_ALLOC, 9'd0,   8'd0,  1'b1, 8'd0, ST_OK},
            '{REQ_ALLOC, 9'd1,   8'd0,  1'b0, 8'd0, ST_OK},
            '{REQ_ALLOC, 9'd2,   8'd0,  1'b0, 8'd0, ST_OK},
            '{REQ_ALLOC, 9'd128, 8'd0,  1'b0, 8'd0, ST_OK},
            '{REQ_ALLOC, 9'd128, 8'd0,  1'b1, 8'd0, ST_NOSPACE},
            '{REQ_ALLOC, 9'd64,  8'd0,  1'b0, 8'd0, ST_OK},
            '{REQ_FREE,  9'd0,   8'd3,  1'b0, 8'd0, ST_OK},
            '{REQ_FREE,  9'd0,   8'd2,  1'b0, 8'd0, ST_OK},
            '{REQ_FREE,  9'd0,   8'd255, 1'b0, 8'd0, ST_OK},
            '{REQ_FREE,  9'd0,   8'd200, 1'b0, 8'd0, ST_OK},
            '{REQ_ALLOC, 9'd255, 8'd0,  1'b0, 8'd0, ST_OK},
            '{REQ_FREE,  9'd0,   8'd129, 1'b0, 8'd0, ST_OK},
            '{REQ_FREE,  9'd0,   8'd0,  1'b0, 8'd0, ST_OK},
            '{REQ_FREE,  9'd0,   8'd1,  1'b0, 8'd0, ST_OK},
            '{REQ_FREE,  9'd0,   8'd64, 1'b0, 8'd0, ST_OK},
            '{REQ_ALLOC, 9'd3,   8'd0,  1'b0, 8'd0, ST_OK},
            '{REQ_ALLOC, 9'd256, 8'd0,  1'b0, 8'd0, ST_OK},
            '{REQ_FREE,  9'd0,   8'd5,  1'b0, 8'd0, ST_OK},
            '{REQ_FREE,  9'd0,   8'd2,  1'b0, 8'd0, ST_OK}
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            r.kind   = directed[i].kind;
            r.size   = directed[i].size;
            r.offset = directed[i].offset;
            issue(r, directed[i].typed, res_t'{directed[i].t_off, directed[i].t_stat});
        end
        // The directed rows leave live-block bookkeeping that no longer matches; start clean.
        live_base.delete();
        live_len.delete();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3) begin
                tx_idle_pct = 82;
                rx_idle_pct = 37;
            end else if (i == 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            roll = $urandom_range(99);
            // Lean toward frees as the pool fills so that the tree keeps changing shape.
            alloc_pct = (free_span[0] >= 9'd32) ? 60 : 25;
            if (roll < alloc_pct) begin
                pick     = $urandom_range(99);
                r.kind   = REQ_ALLOC;
                r.offset = 8'($urandom);
                if (pick < 80) r.size = 9'($urandom_range(1, 16));
                else if (pick < 95) r.size = 9'($urandom_range(17, 256));
                else r.size = 9'($urandom_range(0, 511));
            end else if (roll < 90 && live_base.size() != 0) begin
                idx      = $urandom_range(live_base.size() - 1);
                r.kind   = REQ_FREE;
                r.size   = 9'($urandom);
                r.offset = 8'(live_base[idx] + $urandom_range(live_len[idx] - 1));
                live_base.delete(idx);
                live_len.delete(idx);
            end else begin
                r.kind   = REQ_FREE;
                r.size   = 9'($urandom);
                r.offset = 8'($urandom);
            end
            issue(r, 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("Covered %0d granted and %0d refused allocations, %0d frees and %0d empty frees,",
                 n_granted, n_refused, n_released, n_empty_free);
        $display("under three pacing phases on both the request and result sides.");
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
design/bat_pkg.sv
design/bat_ram.sv
design/bat_ctrl.sv
design/buddy_allocator_tree.sv
sim/tb_buddy_allocator_tree.sv
